[sv/crcr_pkg.sv]
// Shared types and constants of the circle and rectangle collision block.
package crcr_pkg;

	localparam int FRAC_BITS_DEF = 12;
	localparam int NORM_W = 14;
	localparam int DSQ_W = 38;
	localparam int SQ_W = 37;

	typedef enum logic [2:0] {
		CT_NONE   = 3'd0,
		CT_LEFT   = 3'd1,
		CT_BOTTOM = 3'd2,
		CT_RIGHT  = 3'd3,
		CT_TOP    = 3'd4,
		CT_CORNER = 3'd5
	} contact_t;

	typedef struct packed {
		logic     hit;
		contact_t contact;
		logic     zero_d;
		logic     neg_x;
		logic     neg_y;
	} ctl_t;

endpackage

[sv/crcr_if.sv]
// Request and result channel interfaces of the collision block.
interface crcr_req_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] ball_x;
	logic signed [15:0] ball_y;
	logic        [14:0] ball_radius;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic signed [15:0] rect_x;
	logic signed [15:0] rect_y;
	logic        [14:0] rect_width;
	logic        [14:0] rect_height;

	modport source (output valid, ball_x, ball_y, ball_radius, vel_x, vel_y, rect_x, rect_y,
		rect_width, rect_height, input ready);
	modport sink (input valid, ball_x, ball_y, ball_radius, vel_x, vel_y, rect_x, rect_y,
		rect_width, rect_height, output ready);
endinterface

interface crcr_res_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic        [2:0]  contact;
	logic signed [13:0] normal_x;
	logic signed [13:0] normal_y;

	modport source (output valid, hit, contact, normal_x, normal_y, input ready);
	modport sink (input valid, hit, contact, normal_x, normal_y, output ready);
endinterface

[sv/crcr_root.sv]
// One digit step of the corner normal search for both normal components.
module crcr_root #(
	parameter int FRAC_BITS = crcr_pkg::FRAC_BITS_DEF,
	parameter int BIT_IDX = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            ready,
	input  logic                            nxt_ready,
	output logic                            out_valid,
	input  crcr_pkg::ctl_t                  ctl_i,
	output crcr_pkg::ctl_t                  ctl_o,
	input  logic [crcr_pkg::DSQ_W-1:0]      dsq_i,
	output logic [crcr_pkg::DSQ_W-1:0]      dsq_o,
	input  logic signed [2*FRAC_BITS+43:0]  ex_i,
	input  logic signed [2*FRAC_BITS+43:0]  ax_i,
	input  logic signed [2*FRAC_BITS+43:0]  rx_i,
	input  logic signed [2*FRAC_BITS+43:0]  ey_i,
	input  logic signed [2*FRAC_BITS+43:0]  ay_i,
	input  logic signed [2*FRAC_BITS+43:0]  ry_i,
	input  logic [FRAC_BITS:0]              mx_i,
	input  logic [FRAC_BITS:0]              my_i,
	output logic signed [2*FRAC_BITS+43:0]  ex_o,
	output logic signed [2*FRAC_BITS+43:0]  ax_o,
	output logic signed [2*FRAC_BITS+43:0]  rx_o,
	output logic signed [2*FRAC_BITS+43:0]  ey_o,
	output logic signed [2*FRAC_BITS+43:0]  ay_o,
	output logic signed [2*FRAC_BITS+43:0]  ry_o,
	output logic [FRAC_BITS:0]              mx_o,
	output logic [FRAC_BITS:0]              my_o
);
	import crcr_pkg::*;

	localparam int EW = 2*FRAC_BITS+44;

	logic              valid_q;
	ctl_t              ctl_q;
	logic [DSQ_W-1:0]  dsq_q;
	logic signed [EW-1:0] ex_q, ax_q, rx_q, ey_q, ay_q, ry_q;
	logic [FRAC_BITS:0] mx_q, my_q;
	logic signed [EW-1:0] dsq_e, cand_x, cand_y;
	logic take_x, take_y;

	// Trying digit b moves t = 2m-1 to t+2b, so t*t*dsq grows by 4b*t*dsq + 4b*b*dsq.
	assign dsq_e  = $signed({{(EW-DSQ_W){1'b0}}, dsq_i});
	assign cand_x = ex_i + (ax_i <<< (BIT_IDX+2)) + (dsq_e <<< (2*BIT_IDX+2));
	assign cand_y = ey_i + (ay_i <<< (BIT_IDX+2)) + (dsq_e <<< (2*BIT_IDX+2));
	assign take_x = cand_x <= rx_i;
	assign take_y = cand_y <= ry_i;
	assign ready  = !valid_q || nxt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready) begin
			ctl_q <= ctl_i;
			dsq_q <= dsq_i;
			rx_q  <= rx_i;
			ry_q  <= ry_i;
			ex_q  <= take_x ? cand_x : ex_i;
			ey_q  <= take_y ? cand_y : ey_i;
			ax_q  <= take_x ? ax_i + (dsq_e <<< (BIT_IDX+1)) : ax_i;
			ay_q  <= take_y ? ay_i + (dsq_e <<< (BIT_IDX+1)) : ay_i;
			mx_q  <= mx_i | ({{FRAC_BITS{1'b0}}, take_x} << BIT_IDX);
			my_q  <= my_i | ({{FRAC_BITS{1'b0}}, take_y} << BIT_IDX);
		end
	end

	assign out_valid = valid_q;
	assign ctl_o = ctl_q;
	assign dsq_o = dsq_q;
	assign ex_o = ex_q;
	assign ax_o = ax_q;
	assign rx_o = rx_q;
	assign ey_o = ey_q;
	assign ay_o = ay_q;
	assign ry_o = ry_q;
	assign mx_o = mx_q;
	assign my_o = my_q;

	a_err_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (ex_q >= 0 && ey_q >= 0))
		else $error("root error term went negative");
	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (ex_q <= rx_q || mx_q == '0) && (ey_q <= ry_q || my_q == '0))
		else $error("accepted digit exceeds bound");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !nxt_ready) |=> (valid_q && $stable(mx_q) && $stable(my_q)))
		else $error("stalled root stage changed");
endmodule

[sv/circle_rect_collision_reflect.sv]
// Top level of the circle and axis-aligned rectangle collision and reflection block.
//
// Requests arrive on item_in: circle center, radius and velocity and rectangle center
// and full size, all in Q4.12. Each request gives exactly one result on result_out:
// a hit flag, the contact kind and the reflection normal. Edges are checked first in the
// order left, bottom, right, top; corners only when no edge touches.
// The block is a pipeline of FRAC_BITS+6 register stages. While the receiver takes results
// at once, one request is accepted every cycle. The depth is set by the corner normal, which
// is found one digit per stage over FRAC_BITS+1 stages after four stages of geometry.
// Every stage moves forward when it is empty or the next stage moves, so gaps close up
// while the receiver stalls and a full pipeline holds every request without loss.
// Reset clears all valid bits; no result is shown until a request has gone through.
module circle_rect_collision_reflect #(
	parameter int FRAC_BITS = crcr_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	crcr_req_if.sink  item_in,
	crcr_res_if.source result_out
);
	import crcr_pkg::*;

	localparam int EW = 2*FRAC_BITS+44;
	localparam int NR = FRAC_BITS+1;

	// Stage 1: doubled coordinates and rectangle sides.
	logic v_s1, rdy_s1;
	logic signed [16:0] cx_s1, cy_s1;
	logic [15:0] r_s1;
	logic signed [15:0] vx_s1, vy_s1;
	logic signed [17:0] left_s1, right_s1, bot_s1, top_s1;
	logic wz_s1, hz_s1;
	// Stage 2: offsets of the center from the sides.
	logic v_s2, rdy_s2;
	logic signed [18:0] dxl_s2, dxr_s2, dyb_s2, dyt_s2;
	logic [15:0] r_s2;
	logic signed [15:0] vx_s2, vy_s2;
	logic wz_s2, hz_s2;
	// Stage 3: edge tests and products.
	logic v_s3, rdy_s3;
	logic tl_s3, tb_s3, tr_s3, tt_s3;
	logic vxp_s3, vxn_s3, vyp_s3, vyn_s3;
	logic sxl_s3, sxr_s3, syb_s3, syt_s3;
	logic [SQ_W-1:0] sqxl_s3, sqxr_s3, sqyb_s3, sqyt_s3;
	logic [31:0] r2_s3;
	logic signed [34:0] pxl_s3, pxr_s3, pyb_s3, pyt_s3;
	// Stage 4: decision and selected corner.
	logic v_s4, rdy_s4;
	ctl_t ctl_s4;
	logic [DSQ_W-1:0] dsq_s4;
	logic [SQ_W-1:0] sqx_s4, sqy_s4;
	// Output stage.
	logic v_so, rdy_so;
	logic hit_so;
	logic [2:0] contact_so;
	logic signed [NORM_W-1:0] nx_so, ny_so;

	logic signed [18:0] rs;
	logic signed [37:0] psq_xl, psq_xr, psq_yb, psq_yt;
	logic [DSQ_W-1:0] dsq_c [4];
	logic [SQ_W-1:0] sqx_c [4];
	logic [SQ_W-1:0] sqy_c [4];
	logic nx_c [4];
	logic ny_c [4];
	logic signed [35:0] dot_c [4];
	logic ok_c [4];
	ctl_t ctl_n;
	logic [DSQ_W-1:0] dsq_n;
	logic [SQ_W-1:0] sqx_n, sqy_n;
	logic signed [31:0] one_w, nx_w, ny_w;

	logic v_r [NR+1];
	logic rdy_r [NR+1];
	ctl_t ctl_r [NR+1];
	logic [DSQ_W-1:0] dsq_r [NR+1];
	logic signed [EW-1:0] ex_r [NR+1];
	logic signed [EW-1:0] ax_r [NR+1];
	logic signed [EW-1:0] rx_r [NR+1];
	logic signed [EW-1:0] ey_r [NR+1];
	logic signed [EW-1:0] ay_r [NR+1];
	logic signed [EW-1:0] ry_r [NR+1];
	logic [FRAC_BITS:0] mx_r [NR+1];
	logic [FRAC_BITS:0] my_r [NR+1];

	assign rdy_so = !v_so || result_out.ready;
	assign rdy_s4 = !v_s4 || rdy_r[0];
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign item_in.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_so <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= item_in.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_so) v_so <= v_r[NR];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			cx_s1    <= {item_in.ball_x, 1'b0};
			cy_s1    <= {item_in.ball_y, 1'b0};
			r_s1     <= {item_in.ball_radius, 1'b0};
			vx_s1    <= item_in.vel_x;
			vy_s1    <= item_in.vel_y;
			left_s1  <= $signed({item_in.rect_x[15], item_in.rect_x, 1'b0})
				- $signed({3'b000, item_in.rect_width});
			right_s1 <= $signed({item_in.rect_x[15], item_in.rect_x, 1'b0})
				+ $signed({3'b000, item_in.rect_width});
			bot_s1   <= $signed({item_in.rect_y[15], item_in.rect_y, 1'b0})
				- $signed({3'b000, item_in.rect_height});
			top_s1   <= $signed({item_in.rect_y[15], item_in.rect_y, 1'b0})
				+ $signed({3'b000, item_in.rect_height});
			wz_s1    <= item_in.rect_width == '0;
			hz_s1    <= item_in.rect_height == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			dxl_s2 <= $signed({{2{cx_s1[16]}}, cx_s1}) - $signed({left_s1[17], left_s1});
			dxr_s2 <= $signed({{2{cx_s1[16]}}, cx_s1}) - $signed({right_s1[17], right_s1});
			dyb_s2 <= $signed({{2{cy_s1[16]}}, cy_s1}) - $signed({bot_s1[17], bot_s1});
			dyt_s2 <= $signed({{2{cy_s1[16]}}, cy_s1}) - $signed({top_s1[17], top_s1});
			r_s2   <= r_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			wz_s2  <= wz_s1;
			hz_s2  <= hz_s1;
		end
	end

	assign rs = $signed({3'b000, r_s2});
	assign psq_xl = 38'(dxl_s2) * 38'(dxl_s2);
	assign psq_xr = 38'(dxr_s2) * 38'(dxr_s2);
	assign psq_yb = 38'(dyb_s2) * 38'(dyb_s2);
	assign psq_yt = 38'(dyt_s2) * 38'(dyt_s2);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			tl_s3   <= !hz_s2 && dyb_s2 >= 0 && dyt_s2 <= 0 && dxl_s2 >= -rs && dxl_s2 <= rs;
			tb_s3   <= !wz_s2 && dxl_s2 >= 0 && dxr_s2 <= 0 && dyb_s2 >= -rs && dyb_s2 <= rs;
			tr_s3   <= !hz_s2 && dyb_s2 >= 0 && dyt_s2 <= 0 && dxr_s2 >= -rs && dxr_s2 <= rs;
			tt_s3   <= !wz_s2 && dxl_s2 >= 0 && dxr_s2 <= 0 && dyt_s2 >= -rs && dyt_s2 <= rs;
			vxp_s3  <= vx_s2 > 0;
			vxn_s3  <= vx_s2 < 0;
			vyp_s3  <= vy_s2 > 0;
			vyn_s3  <= vy_s2 < 0;
			sxl_s3  <= dxl_s2[18];
			sxr_s3  <= dxr_s2[18];
			syb_s3  <= dyb_s2[18];
			syt_s3  <= dyt_s2[18];
			sqxl_s3 <= psq_xl[SQ_W-1:0];
			sqxr_s3 <= psq_xr[SQ_W-1:0];
			sqyb_s3 <= psq_yb[SQ_W-1:0];
			sqyt_s3 <= psq_yt[SQ_W-1:0];
			r2_s3   <= 32'(r_s2) * 32'(r_s2);
			pxl_s3  <= 35'(vx_s2) * 35'(dxl_s2);
			pxr_s3  <= 35'(vx_s2) * 35'(dxr_s2);
			pyb_s3  <= 35'(vy_s2) * 35'(dyb_s2);
			pyt_s3  <= 35'(vy_s2) * 35'(dyt_s2);
		end
	end

	// Corners in the order left-top, left-bottom, right-bottom, right-top.
	always_comb begin
		sqx_c[0] = sqxl_s3; sqy_c[0] = sqyt_s3; nx_c[0] = sxl_s3; ny_c[0] = syt_s3;
		sqx_c[1] = sqxl_s3; sqy_c[1] = sqyb_s3; nx_c[1] = sxl_s3; ny_c[1] = syb_s3;
		sqx_c[2] = sqxr_s3; sqy_c[2] = sqyb_s3; nx_c[2] = sxr_s3; ny_c[2] = syb_s3;
		sqx_c[3] = sqxr_s3; sqy_c[3] = sqyt_s3; nx_c[3] = sxr_s3; ny_c[3] = syt_s3;
		dot_c[0] = 36'(pxl_s3) + 36'(pyt_s3);
		dot_c[1] = 36'(pxl_s3) + 36'(pyb_s3);
		dot_c[2] = 36'(pxr_s3) + 36'(pyb_s3);
		dot_c[3] = 36'(pxr_s3) + 36'(pyt_s3);
		for (int k = 0; k < 4; k++) begin
			dsq_c[k] = {1'b0, sqx_c[k]} + {1'b0, sqy_c[k]};
			ok_c[k]  = dsq_c[k] <= {{(DSQ_W-32){1'b0}}, r2_s3} && dot_c[k] <= 0;
		end
	end

	always_comb begin
		ctl_n = '{hit: 1'b0, contact: CT_NONE, zero_d: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
		dsq_n = dsq_c[0];
		sqx_n = sqx_c[0];
		sqy_n = sqy_c[0];
		if (tl_s3) begin
			if (vxp_s3) begin
				ctl_n.hit = 1'b1;
				ctl_n.contact = CT_LEFT;
			end
		end else if (tb_s3) begin
			if (vyp_s3) begin
				ctl_n.hit = 1'b1;
				ctl_n.contact = CT_BOTTOM;
			end
		end else if (tr_s3) begin
			if (vxn_s3) begin
				ctl_n.hit = 1'b1;
				ctl_n.contact = CT_RIGHT;
			end
		end else if (tt_s3) begin
			if (vyn_s3) begin
				ctl_n.hit = 1'b1;
				ctl_n.contact = CT_TOP;
			end
		end else begin
			for (int k = 3; k >= 0; k--) begin
				if (ok_c[k]) begin
					ctl_n.hit = 1'b1;
					ctl_n.contact = CT_CORNER;
					ctl_n.zero_d = dsq_c[k] == '0;
					ctl_n.neg_x = nx_c[k];
					ctl_n.neg_y = ny_c[k];
					dsq_n = dsq_c[k];
					sqx_n = sqx_c[k];
					sqy_n = sqy_c[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			ctl_s4 <= ctl_n;
			dsq_s4 <= dsq_n;
			sqx_s4 <= sqx_n;
			sqy_s4 <= sqy_n;
		end
	end

	// The search starts at m = 0, that is t = -1, and bounds t*t*dsq by 4*u*u*2^(2*FRAC_BITS).
	assign v_r[0]   = v_s4;
	assign ctl_r[0] = ctl_s4;
	assign dsq_r[0] = dsq_s4;
	assign ex_r[0]  = $signed({{(EW-DSQ_W){1'b0}}, dsq_s4});
	assign ey_r[0]  = $signed({{(EW-DSQ_W){1'b0}}, dsq_s4});
	assign ax_r[0]  = -$signed({{(EW-DSQ_W){1'b0}}, dsq_s4});
	assign ay_r[0]  = -$signed({{(EW-DSQ_W){1'b0}}, dsq_s4});
	assign rx_r[0]  = $signed({{(EW-SQ_W){1'b0}}, sqx_s4}) <<< (2*FRAC_BITS+2);
	assign ry_r[0]  = $signed({{(EW-SQ_W){1'b0}}, sqy_s4}) <<< (2*FRAC_BITS+2);
	assign mx_r[0]  = '0;
	assign my_r[0]  = '0;
	assign rdy_r[NR] = rdy_so;

	for (genvar g = 0; g < NR; g++) begin : g_root
		crcr_root #(
			.FRAC_BITS(FRAC_BITS),
			.BIT_IDX(FRAC_BITS - g)
		) u_root (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_r[g]),
			.ready    (rdy_r[g]),
			.nxt_ready(rdy_r[g+1]),
			.out_valid(v_r[g+1]),
			.ctl_i    (ctl_r[g]),
			.ctl_o    (ctl_r[g+1]),
			.dsq_i    (dsq_r[g]),
			.dsq_o    (dsq_r[g+1]),
			.ex_i     (ex_r[g]),
			.ax_i     (ax_r[g]),
			.rx_i     (rx_r[g]),
			.ey_i     (ey_r[g]),
			.ay_i     (ay_r[g]),
			.ry_i     (ry_r[g]),
			.mx_i     (mx_r[g]),
			.my_i     (my_r[g]),
			.ex_o     (ex_r[g+1]),
			.ax_o     (ax_r[g+1]),
			.rx_o     (rx_r[g+1]),
			.ey_o     (ey_r[g+1]),
			.ay_o     (ay_r[g+1]),
			.ry_o     (ry_r[g+1]),
			.mx_o     (mx_r[g+1]),
			.my_o     (my_r[g+1])
		);
	end

	assign one_w = 32'sd1 <<< FRAC_BITS;

	always_comb begin
		nx_w = '0;
		ny_w = '0;
		unique case (ctl_r[NR].contact)
			CT_LEFT:   nx_w = -one_w;
			CT_BOTTOM: ny_w = -one_w;
			CT_RIGHT:  nx_w = one_w;
			CT_TOP:    ny_w = one_w;
			CT_CORNER: begin
				if (!ctl_r[NR].zero_d) begin
					nx_w = $signed({{(31-FRAC_BITS){1'b0}}, mx_r[NR]});
					ny_w = $signed({{(31-FRAC_BITS){1'b0}}, my_r[NR]});
					if (ctl_r[NR].neg_x) nx_w = -nx_w;
					if (ctl_r[NR].neg_y) ny_w = -ny_w;
				end
			end
			default: begin
				nx_w = '0;
				ny_w = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_so) begin
			hit_so     <= ctl_r[NR].hit;
			contact_so <= ctl_r[NR].contact;
			nx_so      <= nx_w[NORM_W-1:0];
			ny_so      <= ny_w[NORM_W-1:0];
		end
	end

	assign result_out.valid    = v_so;
	assign result_out.hit      = hit_so;
	assign result_out.contact  = contact_so;
	assign result_out.normal_x = nx_so;
	assign result_out.normal_y = ny_so;

	a_hit_contact: assert property (@(posedge clk) disable iff (!arst_n)
		v_so |-> (hit_so == (contact_so != CT_NONE)))
		else $error("hit flag disagrees with contact");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_so && !hit_so) |-> (nx_so == '0 && ny_so == '0))
		else $error("normal set without a hit");
	a_side_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(v_so && (contact_so == CT_LEFT || contact_so == CT_RIGHT)) |-> (ny_so == '0))
		else $error("side contact with vertical normal part");
	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !rdy_r[0]) |=> (v_s4 && $stable(ctl_s4)))
		else $error("decision stage lost a request under stall");
endmodule

[dv/testbench.sv]
// Self-checking testbench for the circle and rectangle collision block.
`timescale 1ns / 100ps

module testbench;
	import crcr_pkg::*;

	typedef struct {
		logic signed [15:0] ball_x, ball_y, vel_x, vel_y, rect_x, rect_y;
		logic        [14:0] ball_radius, rect_width, rect_height;
	} pair_t;

	typedef struct {
		logic               hit;
		contact_t           contact;
		logic signed [13:0] normal_x, normal_y;
	} bounce_t;

	localparam int LIMIT = 300000;

	logic clk = 0;
	logic arst_n = 0;
	crcr_req_if item_in();
	crcr_res_if result_out();

	circle_rect_collision_reflect dut (.clk, .arst_n, .item_in, .result_out);

	pair_t   pending_q[$];
	bounce_t bounce_q[$];
	int      total = 0, accepted = 0, sender_idle = 21, receiver_idle = 46;
	int      errors = 0, cycles = 0, hold = 0;
	bit      held = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic bit edge_touch(longint a0, a1, along, across, line, r);
		longint d;
		d = across - line;
		if (d < 0) d = -d;
		return a0 != a1 && along >= a0 && along <= a1 && d <= r;
	endfunction

	function automatic logic signed [13:0] unit_part(longint u, longint dsq);
		logic [127:0] lhs, rhs, t;
		longint au, lo, hi, m;
		au = u < 0 ? -u : u;
		rhs = 128'(4 * au * au) << (2 * FRAC_BITS_DEF);
		lo = 0;
		hi = 1 << FRAC_BITS_DEF;
		while (lo < hi) begin
			m = (lo + hi + 1) >> 1;
			t = 128'(2 * m - 1);
			lhs = t * t * 128'(dsq);
			if (lhs <= rhs) lo = m;
			else hi = m - 1;
		end
		return u < 0 ? 14'(-lo) : 14'(lo);
	endfunction

	function automatic bounce_t predict_bounce(pair_t p);
		bounce_t b;
		longint cx, cy, r, vx, vy, w, h, lf, rt, bt, tp, one, dx, dy, dsq;
		longint kx[4], ky[4];
		cx = 2 * longint'(p.ball_x);
		cy = 2 * longint'(p.ball_y);
		r = 2 * longint'(p.ball_radius);
		vx = p.vel_x;
		vy = p.vel_y;
		w = p.rect_width;
		h = p.rect_height;
		lf = 2 * longint'(p.rect_x) - w;
		rt = 2 * longint'(p.rect_x) + w;
		bt = 2 * longint'(p.rect_y) - h;
		tp = 2 * longint'(p.rect_y) + h;
		one = 1 << FRAC_BITS_DEF;
		kx = '{lf, lf, rt, rt};
		ky = '{tp, bt, bt, tp};
		b = '{1'b0, CT_NONE, 14'sd0, 14'sd0};
		if (edge_touch(bt, tp, cy, cx, lf, r)) begin
			if (vx > 0) b = '{1'b1, CT_LEFT, 14'(-one), 14'sd0};
		end else if (edge_touch(lf, rt, cx, cy, bt, r)) begin
			if (vy > 0) b = '{1'b1, CT_BOTTOM, 14'sd0, 14'(-one)};
		end else if (edge_touch(bt, tp, cy, cx, rt, r)) begin
			if (vx < 0) b = '{1'b1, CT_RIGHT, 14'(one), 14'sd0};
		end else if (edge_touch(lf, rt, cx, cy, tp, r)) begin
			if (vy < 0) b = '{1'b1, CT_TOP, 14'sd0, 14'(one)};
		end else begin
			for (int i = 0; i < 4; i++) begin
				dx = cx - kx[i];
				dy = cy - ky[i];
				dsq = dx * dx + dy * dy;
				if (dsq <= r * r && vx * (-dx) + vy * (-dy) >= 0) begin
					b.hit = 1'b1;
					b.contact = CT_CORNER;
					if (dsq != 0) begin
						b.normal_x = unit_part(dx, dsq);
						b.normal_y = unit_part(dy, dsq);
					end
					break;
				end
			end
		end
		return b;
	endfunction

	function automatic pair_t make_pair(int bx, by, rad, vx, vy, rx, ry, w, h);
		pair_t p;
		p.ball_x = 16'(bx);
		p.ball_y = 16'(by);
		p.ball_radius = 15'(rad);
		p.vel_x = 16'(vx);
		p.vel_y = 16'(vy);
		p.rect_x = 16'(rx);
		p.rect_y = 16'(ry);
		p.rect_width = 15'(w);
		p.rect_height = 15'(h);
		return p;
	endfunction

	function automatic int jitter(int span);
		return $urandom_range(2 * span) - span;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int rx, ry, w, h, rad, bx, by;
		if ($urandom_range(9) < 2) begin
			p.ball_x = 16'($urandom);
			p.ball_y = 16'($urandom);
			p.ball_radius = 15'($urandom);
			p.vel_x = 16'($urandom);
			p.vel_y = 16'($urandom);
			p.rect_x = 16'($urandom);
			p.rect_y = 16'($urandom);
			p.rect_width = 15'($urandom);
			p.rect_height = 15'($urandom);
			return p;
		end
		rx = jitter(12000);
		ry = jitter(12000);
		w = $urandom_range(9) == 0 ? 0 : $urandom_range(16000);
		h = $urandom_range(9) == 0 ? 0 : $urandom_range(16000);
		rad = $urandom_range(9) == 0 ? $urandom_range(32767) : $urandom_range(4000);
		case ($urandom_range(2))
			0: begin
				bx = rx + ($urandom_range(1) ? w / 2 : -w / 2) + jitter(rad + 50);
				by = ry + jitter(h / 2 + 50);
			end
			1: begin
				bx = rx + jitter(w / 2 + 50);
				by = ry + ($urandom_range(1) ? h / 2 : -h / 2) + jitter(rad + 50);
			end
			default: begin
				bx = rx + ($urandom_range(1) ? w / 2 : -w / 2) + jitter(rad);
				by = ry + ($urandom_range(1) ? h / 2 : -h / 2) + jitter(rad);
			end
		endcase
		return make_pair(bx, by, rad, jitter(32768), jitter(32768), rx, ry, w, h);
	endfunction

	always @(posedge clk) begin
		if (arst_n && (!item_in.valid || item_in.ready)) begin
			if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle) begin
				pair_t p;
				p = pending_q.pop_front();
				item_in.valid <= 1'b1;
				item_in.ball_x <= p.ball_x;
				item_in.ball_y <= p.ball_y;
				item_in.ball_radius <= p.ball_radius;
				item_in.vel_x <= p.vel_x;
				item_in.vel_y <= p.vel_y;
				item_in.rect_x <= p.rect_x;
				item_in.rect_y <= p.rect_y;
				item_in.rect_width <= p.rect_width;
				item_in.rect_height <= p.rect_height;
			end else begin
				item_in.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold > 0) begin
			hold <= hold - 1;
			result_out.ready <= 1'b0;
		end else if (!held && accepted >= 2 * total / 3 + 50) begin
			held <= 1;
			hold <= 300;
			result_out.ready <= 1'b0;
		end else begin
			result_out.ready <= $urandom_range(99) >= receiver_idle;
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_in.valid && item_in.ready) begin
			pair_t p;
			p = '{item_in.ball_x, item_in.ball_y, item_in.vel_x, item_in.vel_y,
				item_in.rect_x, item_in.rect_y, item_in.ball_radius,
				item_in.rect_width, item_in.rect_height};
			bounce_q.push_back(predict_bounce(p));
			accepted <= accepted + 1;
			if (accepted + 1 >= 2 * total / 3) begin
				sender_idle <= 0;
				receiver_idle <= 0;
			end else if (accepted + 1 >= total / 3) begin
				sender_idle <= 46;
				receiver_idle <= 21;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_out.valid && result_out.ready) begin
			if (bounce_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				bounce_t e;
				e = bounce_q.pop_front();
				if (result_out.hit !== e.hit) begin
					$error("hit: expected %0d, actual %0d", e.hit, result_out.hit);
					errors++;
				end
				if (result_out.contact !== e.contact) begin
					$error("contact: expected %0d, actual %0d", e.contact, result_out.contact);
					errors++;
				end
				if (result_out.normal_x !== e.normal_x) begin
					$error("normal_x: expected %0d, actual %0d", e.normal_x,
						result_out.normal_x);
					errors++;
				end
				if (result_out.normal_y !== e.normal_y) begin
					$error("normal_y: expected %0d, actual %0d", e.normal_y,
						result_out.normal_y);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		item_in.valid = 0;
		item_in.ball_x = 0;
		item_in.ball_y = 0;
		item_in.ball_radius = 0;
		item_in.vel_x = 0;
		item_in.vel_y = 0;
		item_in.rect_x = 0;
		item_in.rect_y = 0;
		item_in.rect_width = 0;
		item_in.rect_height = 0;
		result_out.ready = 0;

		pending_q.push_back(make_pair(-6144, 0, 2048, 100, 0, 0, 0, 8192, 8192));
		pending_q.push_back(make_pair(-6144, 0, 2048, -100, 0, 0, 0, 8192, 8192));
		pending_q.push_back(make_pair(0, -6144, 2048, 0, 100, 0, 0, 8192, 8192));
		pending_q.push_back(make_pair(0, -6144, 2048, 0, -100, 0, 0, 8192, 8192));
		pending_q.push_back(make_pair(6144, 0, 2048, -100, 0, 0, 0, 8192, 8192));
		pending_q.push_back(make_pair(6144, 0, 2048, 100, 0, 0, 0, 8192, 8192));
		pending_q.push_back(make_pair(0, 6144, 2048, 0, -100, 0, 0, 8192, 8192));
		pending_q.push_back(make_pair(0, 6144, 2048, 0, 100, 0, 0, 8192, 8192));
		pending_q.push_back(make_pair(-5120, 5120, 2048, 1, -1, 0, 0, 8192, 8192));
		pending_q.push_back(make_pair(-5120, 5120, 2048, -1, 1, 0, 0, 8192, 8192));
		pending_q.push_back(make_pair(5120, -5120, 2048, -3, 7, 0, 0, 8192, 8192));
		pending_q.push_back(make_pair(100, 200, 0, 0, 0, 100, 200, 0, 0));
		pending_q.push_back(make_pair(300, 0, 400, -5, 0, 0, 0, 0, 0));
		pending_q.push_back(make_pair(0, 1000, 2000, 0, -5, 0, 0, 0, 1000));
		pending_q.push_back(make_pair(900, 100, 2000, -5, 0, 0, 0, 1000, 0));
		pending_q.push_back(make_pair(0, 0, 5000, 0, 0, 0, 0, 8192, 8192));
		pending_q.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767));
		pending_q.push_back(make_pair(-32768, -32768, 32767, -32768, -32768, -32768,
			-32768, 32767, 32767));
		pending_q.push_back(make_pair(-32768, 32767, 32767, 32767, -32768, 32767,
			-32768, 0, 32767));
		pending_q.push_back(make_pair(-32768, -32768, 0, 0, 0, 32767, 32767, 0, 0));
		for (int i = 0; i < 750; i++)
			pending_q.push_back(random_pair());
		total = pending_q.size();

		repeat (9) @(posedge clk);
		arst_n <= 1;
		wait (accepted == total && bounce_q.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && bounce_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
